@@ design/twqe_pkg.sv @@
// Shared constants, function codes and register indexes of the triple window query engine.
`default_nettype none

package twqe_pkg;

	// Store and window geometry; the window is banked, one bank per window row
	localparam int STORE_ROWS = 64;
	localparam int WINDOW_ROWS = 8;
	localparam int BANK_BITS = $clog2(WINDOW_ROWS);
	localparam int BANK_DEPTH = STORE_ROWS / WINDOW_ROWS;
	localparam int BANK_AW = $clog2(BANK_DEPTH);

	// Field widths
	localparam int ROW_W = 6;
	localparam int WORD_W = 64;
	localparam int FUNC_W = 5;
	localparam int CNT_W = 4;
	localparam int LEN_W = 4;
	localparam int OFF_W = 6;
	localparam int IDX_W = 2;

	// Stream payload widths
	localparam int IN_DATA_W = 264;
	localparam int OUT_DATA_W = 80;

	// Function codes
	localparam logic [FUNC_W-1:0] FN_NOOP = 5'd0;
	localparam logic [FUNC_W-1:0] FN_ASK_S = 5'd1;
	localparam logic [FUNC_W-1:0] FN_CNT_S_GE = 5'd2;
	localparam logic [FUNC_W-1:0] FN_ASK_SO = 5'd3;
	localparam logic [FUNC_W-1:0] FN_NOOP_ALT = 5'd4;
	localparam logic [FUNC_W-1:0] FN_CNT_S_LE = 5'd5;
	localparam logic [FUNC_W-1:0] FN_CNT_S_EQ = 5'd6;
	localparam logic [FUNC_W-1:0] FN_ASK_O = 5'd7;
	localparam logic [FUNC_W-1:0] FN_UNIQ_S = 5'd8;
	localparam logic [FUNC_W-1:0] FN_CNT_O_GE = 5'd9;
	localparam logic [FUNC_W-1:0] FN_CNT_O_LE = 5'd10;
	localparam logic [FUNC_W-1:0] FN_CNT_O_EQ = 5'd11;
	localparam logic [FUNC_W-1:0] FN_OBJ_EQ = 5'd12;
	localparam logic [FUNC_W-1:0] FN_OBJ_GT = 5'd13;
	localparam logic [FUNC_W-1:0] FN_OBJ_LT = 5'd14;
	localparam logic [FUNC_W-1:0] FN_OBJ_GE = 5'd15;
	localparam logic [FUNC_W-1:0] FN_OBJ_LE = 5'd16;
	localparam logic [FUNC_W-1:0] FN_VALIDATE = 5'd17;
	localparam logic [FUNC_W-1:0] FN_VALIDATE_ALT = 5'd18;
	localparam logic [FUNC_W-1:0] FN_WRITE = 5'd19;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_RUN_PREDICATE = 2'd0;
	localparam logic [IDX_W-1:0] REG_RUN_OFFSET = 2'd1;
	localparam logic [IDX_W-1:0] REG_RUN_LENGTH = 2'd2;

endpackage

`default_nettype wire

@@ design/twqe_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module twqe_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ design/triple_window_query_engine_core.sv @@
// Items pass the query stage, then the result register; one item per cycle unless stalled.
// The window rows sit in WINDOW_ROWS banks (row modulo WINDOW_ROWS), each read once per cycle,
// so a full window is fetched in one registered read and compared in parallel.
// Output backpressure stalls the input stage only while the result register is held.
// Reset clears the stage valids and the configuration (run_length to 8); the store is not
// cleared and holds arbitrary data until rows are written.
`default_nettype none

module triple_window_query_engine_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Input stream
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// tdata, from bit 0: row_index[5:0], subject[63:0], predicate[63:0], object_value[63:0],
	// threshold[63:0], two zero pad bits
	input  wire logic [twqe_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// tuser: func[4:0]
	input  wire logic [twqe_pkg::FUNC_W-1:0]         s_axis_tuser,
	// Output stream
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// tdata, from bit 0: result, match_count[3:0], lanes[3:0], digest[63:0], seven zero pad bits
	output logic      [twqe_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// Configuration write port
	input  wire logic                                cfg_we,
	input  wire logic [twqe_pkg::IDX_W-1:0]          cfg_index,
	input  wire logic [twqe_pkg::WORD_W-1:0]         cfg_data
);

	import twqe_pkg::*;

	// Configuration registers
	logic [WORD_W-1:0] run_predicate_q;
	logic [OFF_W-1:0]  run_offset_q;
	logic [LEN_W-1:0]  run_length_q;

	// Input field unpack
	logic [ROW_W-1:0]  in_row;
	logic [WORD_W-1:0] in_sub;
	logic [WORD_W-1:0] in_pred;
	logic [WORD_W-1:0] in_obj;
	logic [WORD_W-1:0] in_thr;
	logic              in_accept;
	logic              advance;

	// Query stage
	logic              valid_s1;
	logic [FUNC_W-1:0] func_s1;
	logic [WORD_W-1:0] sub_s1;
	logic [WORD_W-1:0] pred_s1;
	logic [WORD_W-1:0] obj_s1;
	logic [WORD_W-1:0] thr_s1;

	// Result register
	logic              out_valid_q;
	logic              result_q;
	logic [CNT_W-1:0]  count_q;
	logic [LEN_W-1:0]  lanes_q;
	logic [WORD_W-1:0] digest_q;

	// Banked window
	logic [LEN_W-1:0]      win_len;
	logic [WINDOW_ROWS-1:0] lane_ok;
	logic [BANK_AW-1:0]    rd_addr [WINDOW_ROWS];
	logic [2*WORD_W-1:0]   rd_data [WINDOW_ROWS];
	logic                  wr_en_row;

	assign in_row  = s_axis_tdata[ROW_W-1:0];
	assign in_sub  = s_axis_tdata[ROW_W +: WORD_W];
	assign in_pred = s_axis_tdata[ROW_W+WORD_W +: WORD_W];
	assign in_obj  = s_axis_tdata[ROW_W+2*WORD_W +: WORD_W];
	assign in_thr  = s_axis_tdata[ROW_W+3*WORD_W +: WORD_W];

	// Handshake: the query stage moves whenever the result register is free or taken
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_predicate_q <= '0;
			run_offset_q    <= '0;
			run_length_q    <= LEN_W'(WINDOW_ROWS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RUN_PREDICATE: run_predicate_q <= cfg_data;
				REG_RUN_OFFSET:    run_offset_q    <= cfg_data[OFF_W-1:0];
				REG_RUN_LENGTH:    run_length_q    <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturate the window length
	assign win_len = (run_length_q > LEN_W'(WINDOW_ROWS)) ? LEN_W'(WINDOW_ROWS) : run_length_q;

	// Rows outside the store are dropped on write
	assign wr_en_row = in_accept && (s_axis_tuser == FN_WRITE) &&
		({1'b0, in_row} < (ROW_W+1)'(STORE_ROWS));

	// One bank per window lane: map each bank to its window row
	for (genvar b = 0; b < WINDOW_ROWS; b++) begin : g_bank
		logic [BANK_BITS-1:0] lane;
		logic [ROW_W:0]       row;

		assign lane = BANK_BITS'(b) - run_offset_q[BANK_BITS-1:0];
		assign row  = {1'b0, run_offset_q} + (ROW_W+1)'(lane);
		assign lane_ok[b] = (LEN_W'(lane) < win_len) && (row < (ROW_W+1)'(STORE_ROWS));
		assign rd_addr[b] = row[ROW_W-1:BANK_BITS];

		twqe_ram #(
			.WIDTH (2*WORD_W),
			.DEPTH (BANK_DEPTH)
		) u_bank (
			.clk   (clk),
			.we    (wr_en_row && (in_row[BANK_BITS-1:0] == BANK_BITS'(b))),
			.waddr (in_row[ROW_W-1:BANK_BITS]),
			.wdata ({in_obj, in_sub}),
			.raddr (rd_addr[b]),
			.rdata (rd_data[b])
		);
	end

	// Query stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Query stage payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_s1 <= s_axis_tuser;
			sub_s1  <= in_sub;
			pred_s1 <= in_pred;
			obj_s1  <= in_obj;
			thr_s1  <= in_thr;
		end
	end

	// Lane compares
	logic [WINDOW_ROWS-1:0] sub_hit;
	logic [WINDOW_ROWS-1:0] obj_hit;
	logic [WINDOW_ROWS-1:0] rel_hit;

	always_comb begin
		for (int b = 0; b < WINDOW_ROWS; b++) begin
			logic [WORD_W-1:0] st_sub;
			logic [WORD_W-1:0] st_obj;
			logic              rel;
			st_sub = rd_data[b][WORD_W-1:0];
			st_obj = rd_data[b][2*WORD_W-1:WORD_W];
			unique case (func_s1)
				FN_OBJ_EQ: rel = (st_obj == obj_s1);
				FN_OBJ_GT: rel = (st_obj > obj_s1);
				FN_OBJ_LT: rel = (st_obj < obj_s1);
				FN_OBJ_GE: rel = (st_obj >= obj_s1);
				FN_OBJ_LE: rel = (st_obj <= obj_s1);
				default:   rel = 1'b0;
			endcase
			sub_hit[b] = lane_ok[b] && (st_sub == sub_s1);
			obj_hit[b] = lane_ok[b] && (st_obj == obj_s1);
			rel_hit[b] = lane_ok[b] && rel;
		end
	end

	// Count matches
	logic [CNT_W-1:0] cnt_sub;
	logic [CNT_W-1:0] cnt_obj;

	always_comb begin
		cnt_sub = '0;
		cnt_obj = '0;
		for (int b = 0; b < WINDOW_ROWS; b++) begin
			cnt_sub = cnt_sub + CNT_W'(sub_hit[b]);
			cnt_obj = cnt_obj + CNT_W'(obj_hit[b]);
		end
	end

	// Evaluate the answer
	logic             is_query;
	logic             is_count;
	logic             use_obj;
	logic [CNT_W-1:0] cnt_sel;
	logic             thr_small;
	logic             cmp_ge;
	logic             cmp_le;
	logic             cmp_eq;
	logic             raw_res;
	logic             res;

	assign is_query = (func_s1 < FN_WRITE) && (func_s1 != FN_NOOP) && (func_s1 != FN_NOOP_ALT);
	assign use_obj  = (func_s1 == FN_CNT_O_GE) || (func_s1 == FN_CNT_O_LE) ||
		(func_s1 == FN_CNT_O_EQ);
	assign cnt_sel  = use_obj ? cnt_obj : cnt_sub;

	// Count against the full-width bound
	assign thr_small = (thr_s1[WORD_W-1:CNT_W] == '0);
	assign cmp_ge    = thr_small && (cnt_sel >= thr_s1[CNT_W-1:0]);
	assign cmp_le    = !thr_small || (cnt_sel <= thr_s1[CNT_W-1:0]);
	assign cmp_eq    = thr_small && (cnt_sel == thr_s1[CNT_W-1:0]);

	always_comb begin
		is_count = 1'b0;
		unique case (func_s1)
			FN_ASK_S:    raw_res = (cnt_sub != '0);
			FN_CNT_S_GE: begin
				is_count = 1'b1;
				raw_res  = cmp_ge;
			end
			FN_ASK_SO:   raw_res = |(sub_hit & obj_hit);
			FN_CNT_S_LE: begin
				is_count = 1'b1;
				raw_res  = cmp_le;
			end
			FN_CNT_S_EQ: begin
				is_count = 1'b1;
				raw_res  = cmp_eq;
			end
			FN_ASK_O:    raw_res = (cnt_obj != '0);
			FN_UNIQ_S: begin
				is_count = 1'b1;
				raw_res  = (cnt_sub == CNT_W'(1));
			end
			FN_CNT_O_GE: begin
				is_count = 1'b1;
				raw_res  = cmp_ge;
			end
			FN_CNT_O_LE: begin
				is_count = 1'b1;
				raw_res  = cmp_le;
			end
			FN_CNT_O_EQ: begin
				is_count = 1'b1;
				raw_res  = cmp_eq;
			end
			FN_VALIDATE, FN_VALIDATE_ALT: raw_res = |(sub_hit & obj_hit);
			default:     raw_res = |rel_hit;
		endcase
	end

	// Mask by predicate, except for ask-subject
	assign res = is_query && raw_res &&
		((func_s1 == FN_ASK_S) || (pred_s1 == run_predicate_q));

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res;
			count_q  <= (is_query && is_count) ? cnt_sel : '0;
			lanes_q  <= is_query ? LEN_W'(WINDOW_ROWS) : '0;
			digest_q <= is_query ?
				(sub_s1 ^ pred_s1 ^ obj_s1 ^ thr_s1 ^ run_predicate_q ^
				 WORD_W'(is_count ? cnt_sel : '0) ^ WORD_W'(res)) : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, digest_q, lanes_q, count_q, result_q};

endmodule

`default_nettype wire

@@ design/twqe_checker.sv @@
// Port-level checker of the triple window query engine core and its bind.
`default_nettype none

module twqe_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_axis_tvalid,
	input wire logic                            s_axis_tready,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [twqe_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	import twqe_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed or dropped");

	// Input backpressure only comes from a held result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with the result register empty");

	// An accepted transaction is followed by a valid result once it has passed the query stage and the result register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
		else $error("no result after an accepted transaction");

	// Noop, write and unused-code results carry all zeros
	a_noop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[8:5] == '0) |-> (m_axis_tdata[72:0] == '0))
		else $error("noop or write result not zero");

	// A nonzero count belongs to a query with a full lane count
	a_count_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[4:1] != '0) |->
			(m_axis_tdata[8:5] == LEN_W'(WINDOW_ROWS)) &&
			(m_axis_tdata[4:1] <= CNT_W'(WINDOW_ROWS)))
		else $error("match count inconsistent with lanes");

endmodule

bind triple_window_query_engine_core twqe_checker u_twqe_checker (.*);

`default_nettype wire

@@ verif/query_answer_checker.sv @@
// Scoreboard for the triple window query engine: predicts each answer and compares results.
module query_answer_checker
	import twqe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	// tdata, from bit 0: row_index, subject, predicate, object_value, threshold, pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: func
	input  logic [FUNC_W-1:0]     s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// tdata, from bit 0: result, match_count, lanes, digest, pad
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_we,
	input  logic [IDX_W-1:0]      cfg_index,
	input  logic [WORD_W-1:0]     cfg_data,
	output int                    mismatch_count,
	output int                    answers_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic              result;
		logic [CNT_W-1:0]  match_count;
		logic [CNT_W-1:0]  lanes;
		logic [WORD_W-1:0] digest;
	} answer_t;

	// Shadow copy of the store and the window registers
	logic [WORD_W-1:0] subj_mem [STORE_ROWS];
	logic [WORD_W-1:0] obj_mem [STORE_ROWS];
	logic [WORD_W-1:0] cfg_pred;
	logic [OFF_W-1:0]  win_offset;
	logic [LEN_W-1:0]  win_length;

	answer_t expected_answers [$];
	answer_t due_answer;
	answer_t seen_answer;

	logic [FUNC_W-1:0] in_func;
	logic [ROW_W-1:0]  in_row;
	logic [WORD_W-1:0] in_subj;
	logic [WORD_W-1:0] in_pred;
	logic [WORD_W-1:0] in_obj;
	logic [WORD_W-1:0] in_k;

	// Compute the answer of one item against the current store and window
	function automatic answer_t predict_answer(input logic [FUNC_W-1:0] fn,
		input logic [WORD_W-1:0] subj, input logic [WORD_W-1:0] pred,
		input logic [WORD_W-1:0] obj, input logic [WORD_W-1:0] k);
		answer_t ans;
		int span;
		int r;
		logic [WORD_W-1:0] subj_hits;
		logic [WORD_W-1:0] obj_hits;
		logic [WORD_W-1:0] cnt;
		logic pair_hit;
		logic rel_hit;
		logic counted;
		logic res;
		ans = '0;
		if (fn == FN_NOOP || fn == FN_NOOP_ALT || fn >= FN_WRITE)
			return ans;
		span = (win_length > WINDOW_ROWS) ? WINDOW_ROWS : int'(win_length);
		subj_hits = '0;
		obj_hits = '0;
		cnt = '0;
		pair_hit = 1'b0;
		rel_hit = 1'b0;
		counted = 1'b0;
		res = 1'b0;
		// Scan the window; rows past the store end take no part
		for (int i = 0; i < span; i++) begin
			r = int'(win_offset) + i;
			if (r < STORE_ROWS) begin
				if (subj_mem[r] == subj)
					subj_hits++;
				if (obj_mem[r] == obj)
					obj_hits++;
				if (subj_mem[r] == subj && obj_mem[r] == obj)
					pair_hit = 1'b1;
				case (fn)
				FN_OBJ_EQ: if (obj_mem[r] == obj) rel_hit = 1'b1;
				FN_OBJ_GT: if (obj_mem[r] > obj) rel_hit = 1'b1;
				FN_OBJ_LT: if (obj_mem[r] < obj) rel_hit = 1'b1;
				FN_OBJ_GE: if (obj_mem[r] >= obj) rel_hit = 1'b1;
				FN_OBJ_LE: if (obj_mem[r] <= obj) rel_hit = 1'b1;
				default: ;
				endcase
			end
		end
		case (fn)
		FN_ASK_S: res = subj_hits != 0;
		FN_CNT_S_GE: begin
			counted = 1'b1;
			cnt = subj_hits;
			res = cnt >= k;
		end
		FN_CNT_S_LE: begin
			counted = 1'b1;
			cnt = subj_hits;
			res = cnt <= k;
		end
		FN_CNT_S_EQ: begin
			counted = 1'b1;
			cnt = subj_hits;
			res = cnt == k;
		end
		FN_UNIQ_S: begin
			counted = 1'b1;
			cnt = subj_hits;
			res = cnt == 1;
		end
		FN_ASK_O: res = obj_hits != 0;
		FN_CNT_O_GE: begin
			counted = 1'b1;
			cnt = obj_hits;
			res = cnt >= k;
		end
		FN_CNT_O_LE: begin
			counted = 1'b1;
			cnt = obj_hits;
			res = cnt <= k;
		end
		FN_CNT_O_EQ: begin
			counted = 1'b1;
			cnt = obj_hits;
			res = cnt == k;
		end
		FN_ASK_SO, FN_VALIDATE, FN_VALIDATE_ALT: res = pair_hit;
		default: res = rel_hit;
		endcase
		// Mask the answer on a predicate miss, except for ask-subject
		if (fn != FN_ASK_S && pred != cfg_pred)
			res = 1'b0;
		ans.result = res;
		ans.match_count = counted ? cnt[CNT_W-1:0] : '0;
		ans.lanes = CNT_W'(WINDOW_ROWS);
		ans.digest = subj ^ pred ^ obj ^ k ^ (counted ? cnt : '0) ^ WORD_W'(res) ^ cfg_pred;
		return ans;
	endfunction

	// Track register writes, accepted items and accepted results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_answers.delete();
			cfg_pred = '0;
			win_offset = '0;
			win_length = LEN_W'(WINDOW_ROWS);
			mismatch_count = 0;
			answers_pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_RUN_PREDICATE: cfg_pred = cfg_data;
				REG_RUN_OFFSET: win_offset = cfg_data[OFF_W-1:0];
				REG_RUN_LENGTH: win_length = cfg_data[LEN_W-1:0];
				default: ;
				endcase
			end

			// Predict the answer of an input transaction, then apply a write
			if (s_axis_tvalid && s_axis_tready) begin
				in_func = s_axis_tuser;
				in_row = s_axis_tdata[5:0];
				in_subj = s_axis_tdata[69:6];
				in_pred = s_axis_tdata[133:70];
				in_obj = s_axis_tdata[197:134];
				in_k = s_axis_tdata[261:198];
				expected_answers.push_back(predict_answer(in_func, in_subj, in_pred,
					in_obj, in_k));
				if (in_func == FN_WRITE) begin
					subj_mem[in_row] = in_subj;
					obj_mem[in_row] = in_obj;
				end
			end

			// Compare a result transaction with the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				seen_answer.result = m_axis_tdata[0];
				seen_answer.match_count = m_axis_tdata[4:1];
				seen_answer.lanes = m_axis_tdata[8:5];
				seen_answer.digest = m_axis_tdata[72:9];
				if (expected_answers.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result transaction: %h", m_axis_tdata);
				end else begin
					due_answer = expected_answers.pop_front();
					if (seen_answer.result !== due_answer.result
						|| seen_answer.match_count !== due_answer.match_count
						|| seen_answer.lanes !== due_answer.lanes
						|| seen_answer.digest !== due_answer.digest) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"mismatch at %0t (expected/actual): result %b/%b ",
								"count %0d/%0d lanes %0d/%0d digest %h/%h"}, $realtime,
								due_answer.result, seen_answer.result,
								due_answer.match_count, seen_answer.match_count,
								due_answer.lanes, seen_answer.lanes,
								due_answer.digest, seen_answer.digest);
					end
				end
			end
			answers_pending = expected_answers.size();
		end
	end

endmodule

@@ verif/triple_window_query_engine_core_tb.sv @@
// Top of the triple window query engine testbench: clock, reset, stimulus and verdict.
module triple_window_query_engine_core_tb;
	import twqe_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [FUNC_W-1:0] FN_LAST_UNUSED = '1;
	localparam int PHASE_ITEMS = 60;
	localparam int PHASES = 8;
	localparam int LONG_HOLD = 200;
	localparam int DRAIN_CYCLES = 8;
	localparam int TIMEOUT_NS = 2_000_000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [FUNC_W-1:0]     s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we = 1'b0;
	logic [IDX_W-1:0]      cfg_index = '0;
	logic [WORD_W-1:0]     cfg_data = '0;

	int mismatch_count;
	int answers_pending;

	// Stimulus state: idling rates, window in force, rows already written
	int gap_pct = 0;
	int stall_pct = 0;
	int holds_requested = 0;
	int holds_served = 0;
	int hold_left = 0;
	logic [WORD_W-1:0] cur_pred = '0;
	int cur_off = 0;
	logic [STORE_ROWS-1:0] row_written = '0;
	logic [WORD_W-1:0] subj_pool [4];
	logic [WORD_W-1:0] obj_pool [4];

	triple_window_query_engine_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	query_answer_checker answer_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.answers_pending (answers_pending)
	);

	always #4 clk = ~clk;

	// Drive the result-side ready: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (holds_served != holds_requested) begin
			holds_served <= holds_requested;
			hold_left <= LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// End the run if it hangs
	initial begin
		#(TIMEOUT_NS);
		$display("simulation failed");
		$finish;
	end

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [WORD_W-1:0] pick_subject();
		if ($urandom_range(99) < 75)
			return subj_pool[$urandom_range(3)];
		return rand_word();
	endfunction

	function automatic logic [WORD_W-1:0] pick_object();
		if ($urandom_range(99) < 70)
			return obj_pool[$urandom_range(3)];
		return rand_word();
	endfunction

	// Offer one item after random idle cycles and hold it until the transaction
	task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [ROW_W-1:0] row,
		input logic [WORD_W-1:0] subj, input logic [WORD_W-1:0] pred,
		input logic [WORD_W-1:0] obj, input logic [WORD_W-1:0] k);
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= fn;
		s_axis_tdata <= {2'b00, k, obj, pred, subj, row};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		if (fn == FN_WRITE)
			row_written[row] = 1'b1;
	endtask

	// Drop valid and wait until every predicted answer has come back
	task automatic pause_until_drained();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (answers_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write all three window registers, then fill any unwritten row of the window
	task automatic set_window(input logic [WORD_W-1:0] pred, input int off, input int len);
		int r;
		cfg_we <= 1'b1;
		cfg_index <= REG_RUN_PREDICATE;
		cfg_data <= pred;
		@(negedge clk);
		cfg_index <= REG_RUN_OFFSET;
		cfg_data <= WORD_W'(off);
		@(negedge clk);
		cfg_index <= REG_RUN_LENGTH;
		cfg_data <= WORD_W'(len);
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_pred = pred;
		cur_off = off;
		for (int i = 0; i < WINDOW_ROWS; i++) begin
			r = off + i;
			if (i < len && r < STORE_ROWS && !row_written[r])
				send_item(FN_WRITE, ROW_W'(r), pick_subject(), rand_word(), pick_object(),
					rand_word());
		end
	endtask

	// Build one random item: writes, noops, unused codes and queries with pooled words
	task automatic send_random_item();
		int roll;
		logic [FUNC_W-1:0] fn;
		logic [ROW_W-1:0] row;
		logic [WORD_W-1:0] pred;
		logic [WORD_W-1:0] k;
		roll = $urandom_range(99);
		row = ROW_W'($urandom_range(STORE_ROWS - 1));
		if (roll < 15) begin
			fn = FN_WRITE;
			if ($urandom_range(1) == 1)
				row = ROW_W'((cur_off + $urandom_range(WINDOW_ROWS - 1)) % STORE_ROWS);
		end else if (roll < 20) begin
			case ($urandom_range(2))
			0: fn = FN_NOOP;
			1: fn = FN_NOOP_ALT;
			default: fn = FUNC_W'($urandom_range(FN_WRITE + 1, FN_LAST_UNUSED));
			endcase
		end else begin
			fn = FUNC_W'($urandom_range(FN_ASK_S, FN_VALIDATE_ALT));
		end
		pred = ($urandom_range(99) < 85) ? cur_pred : rand_word();
		roll = $urandom_range(99);
		if (roll < 60)
			k = WORD_W'($urandom_range(9));
		else if (roll < 75)
			k = '1;
		else
			k = rand_word();
		send_item(fn, row, pick_subject(), pred, pick_object(), k);
	endtask

	initial begin : stimulus
		logic [WORD_W-1:0] sa;
		logic [WORD_W-1:0] oc;
		logic [WORD_W-1:0] dp;
		sa = 64'h0123_4567_89AB_CDEF;
		oc = 64'h8000_0000_0000_0001;
		dp = 64'hA5A5_0000_FFFF_1234;
		subj_pool = '{'0, '1, sa, rand_word()};
		obj_pool = '{'0, '1, oc, rand_word()};

		// Hold reset, then release it on a falling edge
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: a four-row window with duplicate subjects and extreme objects
		set_window(dp, 0, 4);
		send_item(FN_WRITE, ROW_W'(0), sa, '0, '1, '0);
		send_item(FN_WRITE, ROW_W'(1), sa, '1, '0, '1);
		send_item(FN_WRITE, ROW_W'(2), sa, dp, oc, '0);
		send_item(FN_WRITE, ROW_W'(3), '1, '0, oc, '1);
		// Every function code but write once, then the unused top code
		for (int f = FN_NOOP; f <= FN_WRITE; f++) begin
			if (f != FN_WRITE)
				send_item(FUNC_W'(f), ROW_W'(f), sa, dp, oc, 64'd2);
		end
		send_item(FN_LAST_UNUSED, '1, sa, dp, oc, 64'd2);
		// Predicate miss: ask-subject stays unmasked, a count is forced low
		send_item(FN_ASK_S, '0, sa, ~dp, oc, 64'd2);
		send_item(FN_CNT_S_GE, '0, sa, ~dp, oc, 64'd2);
		send_item(FN_CNT_S_LE, '0, sa, dp, '1, '1);
		pause_until_drained();

		// Random phases: extremes of the window, empty, saturated and past the store end
		for (int ph = 0; ph < PHASES; ph++) begin
			subj_pool[3] = rand_word();
			obj_pool[3] = rand_word();
			case (ph % 4)
			0: begin gap_pct = 0;  stall_pct = 0;  end
			1: begin gap_pct = 53; stall_pct = 0;  end
			2: begin gap_pct = 0;  stall_pct = 53; end
			default: begin gap_pct = 11; stall_pct = 11; end
			endcase
			case (ph)
			0: set_window('0, 0, WINDOW_ROWS);
			1: set_window('1, STORE_ROWS - WINDOW_ROWS, WINDOW_ROWS);
			2: set_window(rand_word(), $urandom_range(STORE_ROWS - WINDOW_ROWS), 0);
			3: set_window(rand_word(), STORE_ROWS - 4, 15);
			4: set_window(rand_word(), $urandom_range(STORE_ROWS - WINDOW_ROWS),
				$urandom_range(1, WINDOW_ROWS));
			5: set_window(rand_word(), STORE_ROWS - 1, 1);
			6: set_window(rand_word(), $urandom_range(STORE_ROWS - WINDOW_ROWS),
				WINDOW_ROWS);
			default: set_window(rand_word(), $urandom_range(STORE_ROWS - 1),
				$urandom_range(15));
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Fill the pipeline against a long result-side hold-off
				if (ph == 4 && n == 20)
					holds_requested++;
				// Let the block run dry mid-phase
				if (ph == 2 && n == 35)
					pause_until_drained();
				send_random_item();
			end
			pause_until_drained();
		end

		if (mismatch_count == 0 && answers_pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ files.f @@
design/twqe_pkg.sv
design/twqe_ram.sv
design/triple_window_query_engine_core.sv
design/twqe_checker.sv
verif/query_answer_checker.sv
verif/triple_window_query_engine_core_tb.sv
